>>> rtl/pdfst_pkg.sv
// Shared types and constants for the page directory free space table.
// Used by every module of the block but pdfst_ram; depends on nothing.
package pdfst_pkg;

  localparam int NUM_HEAPS = 16;
  localparam int NUM_PAGES = 256;
  localparam int HEAP_W    = 4;
  localparam int PAGE_W    = 8;
  localparam int BLOCK_W   = 16;
  localparam int FREE_W    = 8;
  localparam int FILL_W    = PAGE_W + 1;

  localparam logic [2:0] OP_CREATE  = 3'd0;
  localparam logic [2:0] OP_ADD     = 3'd1;
  localparam logic [2:0] OP_UPDATE  = 3'd2;
  localparam logic [2:0] OP_FETCH   = 3'd3;
  localparam logic [2:0] OP_GETFREE = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_NOSPACE  = 2'd2;

  localparam logic [FREE_W-1:0] DEFAULT_FREE_RST = 8'd4;

  typedef struct packed {
    logic [HEAP_W-1:0]  heap;
    logic [PAGE_W-1:0]  page;
    logic [BLOCK_W-1:0] block;
    logic [FREE_W-1:0]  free;
  } slot_t;

  typedef struct packed {
    logic       latch;
    logic       heap_alloc;
    logic       add_page;
    logic       scan_start;
    logic       scan_run;
    logic       upd_write;
    logic       cap_fetch;
    logic       cap_get;
    logic       pg_start;
    logic       pg_run;
    logic       make_page;
    logic       set_err;
    logic [1:0] err_code;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       heap_known;
    logic       heap_avail;
    logic       full;
    logic       nok;
    logic       hit;
    logic       miss_done;
    logic       pg_free;
    logic       pg_end;
    logic       out_busy;
  } stat_t;

endpackage

>>> rtl/pdfst_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// Standalone; no package dependency.
module pdfst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/pdfst_dp.sv
// Datapath: request registers, heap and page maps, slot store, scan counters
// and result registers. Depends on pdfst_pkg and pdfst_ram.
module pdfst_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pdfst_pkg::cmd_t                cmd_i,
  output pdfst_pkg::stat_t               stat_o,
  input  logic                           cfg_we_i,
  input  logic [pdfst_pkg::FREE_W-1:0]   cfg_wdata_i,
  input  logic [2:0]                     opcode_i,
  input  logic [pdfst_pkg::HEAP_W-1:0]   heap_id_i,
  input  logic [pdfst_pkg::PAGE_W-1:0]   page_id_i,
  input  logic [pdfst_pkg::BLOCK_W-1:0]  disk_block_i,
  input  logic [pdfst_pkg::FREE_W-1:0]   free_space_i,
  input  logic signed [7:0]              delta_i,
  input  logic [pdfst_pkg::BLOCK_W-1:0]  new_block_i,
  input  logic                           new_block_ok_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic [1:0]                     status_o,
  output logic [pdfst_pkg::HEAP_W-1:0]   result_heap_o,
  output logic [pdfst_pkg::PAGE_W-1:0]   result_page_o,
  output logic [pdfst_pkg::BLOCK_W-1:0]  result_block_o,
  output logic                           page_is_new_o
);

  logic [2:0]                      op_q;
  logic [pdfst_pkg::HEAP_W-1:0]    heap_q;
  logic [pdfst_pkg::PAGE_W-1:0]    page_q;
  logic [pdfst_pkg::BLOCK_W-1:0]   blk_q;
  logic [pdfst_pkg::FREE_W-1:0]    fr_q;
  logic signed [7:0]               delta_q;
  logic [pdfst_pkg::BLOCK_W-1:0]   nblk_q;
  logic                            nok_q;

  logic [pdfst_pkg::FREE_W-1:0]    dfs_q;
  logic [pdfst_pkg::NUM_HEAPS-1:0] heap_use_q;
  logic [pdfst_pkg::NUM_PAGES-1:0] page_use_q;
  logic [pdfst_pkg::FILL_W-1:0]    filled_q;

  logic [pdfst_pkg::FILL_W-1:0]    scan_idx_q;
  logic                            pend_q;
  logic [pdfst_pkg::PAGE_W-1:0]    pend_idx_q;
  logic [pdfst_pkg::FILL_W-1:0]    pg_idx_q;

  logic [1:0]                      r_st_q;
  logic [pdfst_pkg::HEAP_W-1:0]    r_heap_q;
  logic [pdfst_pkg::PAGE_W-1:0]    r_page_q;
  logic [pdfst_pkg::BLOCK_W-1:0]   r_blk_q;
  logic                            r_new_q;

  logic                            out_valid_q;
  logic [1:0]                      o_st_q;
  logic [pdfst_pkg::HEAP_W-1:0]    o_heap_q;
  logic [pdfst_pkg::PAGE_W-1:0]    o_page_q;
  logic [pdfst_pkg::BLOCK_W-1:0]   o_blk_q;
  logic                            o_new_q;

  logic                            issue;
  logic                            we;
  logic [pdfst_pkg::PAGE_W-1:0]    waddr;
  pdfst_pkg::slot_t                wdata;
  pdfst_pkg::slot_t                rdata;
  logic [$bits(pdfst_pkg::slot_t)-1:0] rdata_raw;
  logic [pdfst_pkg::HEAP_W-1:0]    heap_enc;
  logic                            heap_any;
  logic signed [9:0]               sum;
  logic [pdfst_pkg::FREE_W-1:0]    sat;
  logic                            match;

  assign issue = cmd_i.scan_run && (scan_idx_q < filled_q);
  assign rdata = pdfst_pkg::slot_t'(rdata_raw);

  always_comb begin
    heap_enc = '0;
    heap_any = 1'b0;
    for (int i = pdfst_pkg::NUM_HEAPS - 1; i >= 0; i--) begin
      if (!heap_use_q[i]) begin
        heap_enc = pdfst_pkg::HEAP_W'(i);
        heap_any = 1'b1;
      end
    end
  end

  assign sum = $signed({2'b00, rdata.free}) + $signed({{2{delta_q[7]}}, delta_q});
  always_comb begin
    priority if (sum < 0) begin
      sat = '0;
    end else if (sum > 10'sd255) begin
      sat = '1;
    end else begin
      sat = sum[7:0];
    end
  end

  always_comb begin
    if (op_q == pdfst_pkg::OP_GETFREE) begin
      match = (rdata.heap == heap_q) && (rdata.free != '0);
    end else begin
      match = (rdata.heap == heap_q) && (rdata.page == page_q);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = filled_q[pdfst_pkg::PAGE_W-1:0];
    wdata = rdata;
    priority if (cmd_i.add_page) begin
      we    = 1'b1;
      wdata = '{heap: heap_q, page: page_q, block: blk_q, free: fr_q};
    end else if (cmd_i.make_page) begin
      we    = 1'b1;
      wdata = '{heap: heap_q, page: pg_idx_q[pdfst_pkg::PAGE_W-1:0],
                block: nblk_q, free: dfs_q};
    end else if (cmd_i.upd_write) begin
      we         = 1'b1;
      waddr      = pend_idx_q;
      wdata.free = sat;
    end else begin
      we = 1'b0;
    end
  end

  pdfst_ram #(
    .WIDTH($bits(pdfst_pkg::slot_t)),
    .DEPTH(pdfst_pkg::NUM_PAGES)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (issue),
    .raddr_i(scan_idx_q[pdfst_pkg::PAGE_W-1:0]),
    .rdata_o(rdata_raw)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q    <= opcode_i;
      heap_q  <= heap_id_i;
      page_q  <= page_id_i;
      blk_q   <= disk_block_i;
      fr_q    <= free_space_i;
      delta_q <= delta_i;
      nblk_q  <= new_block_i;
      nok_q   <= new_block_ok_i;
    end
    if (issue) begin
      pend_idx_q <= scan_idx_q[pdfst_pkg::PAGE_W-1:0];
    end
    if (cmd_i.latch) begin
      r_st_q   <= pdfst_pkg::ST_OK;
      r_heap_q <= '0;
      r_page_q <= '0;
      r_blk_q  <= '0;
      r_new_q  <= 1'b0;
    end else begin
      if (cmd_i.set_err) begin
        r_st_q <= cmd_i.err_code;
      end
      if (cmd_i.heap_alloc) begin
        r_heap_q <= heap_enc;
      end
      if (cmd_i.cap_fetch) begin
        r_blk_q <= rdata.block;
      end
      if (cmd_i.cap_get) begin
        r_page_q <= rdata.page;
        r_blk_q  <= rdata.block;
      end
      if (cmd_i.make_page) begin
        r_page_q <= pg_idx_q[pdfst_pkg::PAGE_W-1:0];
        r_blk_q  <= nblk_q;
        r_new_q  <= 1'b1;
      end
    end
    if (cmd_i.out_load) begin
      o_st_q   <= r_st_q;
      o_heap_q <= r_heap_q;
      o_page_q <= r_page_q;
      o_blk_q  <= r_blk_q;
      o_new_q  <= r_new_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dfs_q       <= pdfst_pkg::DEFAULT_FREE_RST;
      heap_use_q  <= '0;
      page_use_q  <= '0;
      filled_q    <= '0;
      scan_idx_q  <= '0;
      pend_q      <= 1'b0;
      pg_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dfs_q <= cfg_wdata_i;
      end
      if (cmd_i.heap_alloc) begin
        heap_use_q[heap_enc] <= 1'b1;
      end
      if (cmd_i.add_page) begin
        page_use_q[page_q] <= 1'b1;
      end
      if (cmd_i.make_page) begin
        page_use_q[pg_idx_q[pdfst_pkg::PAGE_W-1:0]] <= 1'b1;
      end
      if (cmd_i.add_page || cmd_i.make_page) begin
        filled_q <= filled_q + 1'b1;
      end
      if (cmd_i.scan_start) begin
        scan_idx_q <= '0;
        pend_q     <= 1'b0;
      end else if (cmd_i.scan_run) begin
        scan_idx_q <= scan_idx_q + pdfst_pkg::FILL_W'(issue);
        pend_q     <= issue;
      end
      if (cmd_i.pg_start) begin
        pg_idx_q <= '0;
      end else if (cmd_i.pg_run) begin
        pg_idx_q <= pg_idx_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o.op         = op_q;
    stat_o.heap_known = heap_use_q[heap_q];
    stat_o.heap_avail = heap_any;
    stat_o.full       = (filled_q == pdfst_pkg::FILL_W'(pdfst_pkg::NUM_PAGES));
    stat_o.nok        = nok_q;
    stat_o.hit        = pend_q && match;
    stat_o.miss_done  = !pend_q && !(scan_idx_q < filled_q);
    stat_o.pg_end     = (pg_idx_q == pdfst_pkg::FILL_W'(pdfst_pkg::NUM_PAGES));
    stat_o.pg_free    = !page_use_q[pg_idx_q[pdfst_pkg::PAGE_W-1:0]];
    stat_o.out_busy   = out_valid_q;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = o_st_q;
  assign result_heap_o  = o_heap_q;
  assign result_page_o  = o_page_q;
  assign result_block_o = o_blk_q;
  assign page_is_new_o  = o_new_q;

endmodule

>>> rtl/pdfst_ctrl.sv
// Controller: sequences one request through decode, slot scan, page id
// search and result hand-off. Depends on pdfst_pkg.
module pdfst_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             out_stall_i,
  input  pdfst_pkg::stat_t stat_i,
  output pdfst_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_PSRCH = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_FIN;
        unique case (stat_i.op)
          pdfst_pkg::OP_CREATE: begin
            if (stat_i.heap_avail) begin
              cmd_o.heap_alloc = 1'b1;
            end else begin
              cmd_o.set_err  = 1'b1;
              cmd_o.err_code = pdfst_pkg::ST_NOSPACE;
            end
          end
          pdfst_pkg::OP_ADD: begin
            priority if (!stat_i.heap_known) begin
              cmd_o.set_err  = 1'b1;
              cmd_o.err_code = pdfst_pkg::ST_NOTFOUND;
            end else if (stat_i.full) begin
              cmd_o.set_err  = 1'b1;
              cmd_o.err_code = pdfst_pkg::ST_NOSPACE;
            end else begin
              cmd_o.add_page = 1'b1;
            end
          end
          pdfst_pkg::OP_UPDATE, pdfst_pkg::OP_FETCH, pdfst_pkg::OP_GETFREE: begin
            if (!stat_i.heap_known) begin
              cmd_o.set_err  = 1'b1;
              cmd_o.err_code = pdfst_pkg::ST_NOTFOUND;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end
          end
          default: begin
            cmd_o.set_err  = 1'b1;
            cmd_o.err_code = pdfst_pkg::ST_NOTFOUND;
          end
        endcase
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        priority if (stat_i.hit) begin
          state_d = S_FIN;
          priority if (stat_i.op == pdfst_pkg::OP_UPDATE) begin
            cmd_o.upd_write = 1'b1;
          end else if (stat_i.op == pdfst_pkg::OP_FETCH) begin
            cmd_o.cap_fetch = 1'b1;
          end else begin
            cmd_o.cap_get = 1'b1;
          end
        end else if (stat_i.miss_done) begin
          state_d = S_FIN;
          priority if (stat_i.op != pdfst_pkg::OP_GETFREE) begin
            cmd_o.set_err  = 1'b1;
            cmd_o.err_code = pdfst_pkg::ST_NOTFOUND;
          end else if (!stat_i.nok || stat_i.full) begin
            cmd_o.set_err  = 1'b1;
            cmd_o.err_code = pdfst_pkg::ST_NOSPACE;
          end else begin
            cmd_o.pg_start = 1'b1;
            state_d        = S_PSRCH;
          end
        end else begin
          state_d = S_SCAN;
        end
      end
      S_PSRCH: begin
        priority if (stat_i.pg_end) begin
          cmd_o.set_err  = 1'b1;
          cmd_o.err_code = pdfst_pkg::ST_NOSPACE;
          state_d        = S_FIN;
        end else if (stat_i.pg_free) begin
          cmd_o.make_page = 1'b1;
          state_d         = S_FIN;
        end else begin
          cmd_o.pg_run = 1'b1;
        end
      end
      S_FIN: begin
        if (!stat_i.out_busy || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/page_directory_free_space_table.sv
// Top level of the page directory free space table.
// Depends on pdfst_pkg, pdfst_ctrl, pdfst_dp (and pdfst_ram through it).
//
// Usage: one request on the input channel (valid/stall) yields one result on
// the output channel (valid/stall). A request is taken when in_valid_i is
// high and in_stall_o low; a result is taken when out_valid_o is high and
// out_stall_i low. The block works on one request at a time.
// Create heap, add page and requests rejected at decode go from decode
// straight to the result. Update, fetch and get free page scan the slot
// store one slot a cycle through its single registered read port, from the
// first slot until a hit or until every filled slot is read. Get free page
// that must make a new page then walks the page id map one id a cycle,
// from id 0 up to the first free id or the end of the map.
// The next request is taken as soon as the result is loaded, even if that
// result still waits; a finished request is held back only while the
// previous result is stalled. Configuration writes (cfg_we_i) take effect at
// once. Reset empties the heap and page maps and the directory, and sets
// default free space to 4; the slot store itself is not cleared.
module page_directory_free_space_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pdfst_pkg::FREE_W-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [2:0]                     opcode_i,
  input  logic [pdfst_pkg::HEAP_W-1:0]   heap_id_i,
  input  logic [pdfst_pkg::PAGE_W-1:0]   page_id_i,
  input  logic [pdfst_pkg::BLOCK_W-1:0]  disk_block_i,
  input  logic [pdfst_pkg::FREE_W-1:0]   free_space_i,
  input  logic signed [7:0]              delta_i,
  input  logic [pdfst_pkg::BLOCK_W-1:0]  new_block_i,
  input  logic                           new_block_ok_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     status_o,
  output logic [pdfst_pkg::HEAP_W-1:0]   result_heap_o,
  output logic [pdfst_pkg::PAGE_W-1:0]   result_page_o,
  output logic [pdfst_pkg::BLOCK_W-1:0]  result_block_o,
  output logic                           page_is_new_o
);

  pdfst_pkg::cmd_t  cmd;
  pdfst_pkg::stat_t stat;

  pdfst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pdfst_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .opcode_i      (opcode_i),
    .heap_id_i     (heap_id_i),
    .page_id_i     (page_id_i),
    .disk_block_i  (disk_block_i),
    .free_space_i  (free_space_i),
    .delta_i       (delta_i),
    .new_block_i   (new_block_i),
    .new_block_ok_i(new_block_ok_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .result_heap_o (result_heap_o),
    .result_page_o (result_page_o),
    .result_block_o(result_block_o),
    .page_is_new_o (page_is_new_o)
  );

endmodule

>>> dv/tb_page_directory_free_space_table.sv
// Testbench for the page directory free space table: directed and random requests
// checked result by result against an in-bench prediction of the directory.
// Depends on pdfst_pkg and page_directory_free_space_table.
module tb_page_directory_free_space_table;

  typedef struct packed {
    logic [1:0]                    status;
    logic [pdfst_pkg::HEAP_W-1:0]  heap;
    logic [pdfst_pkg::PAGE_W-1:0]  page;
    logic [pdfst_pkg::BLOCK_W-1:0] block;
    logic                          is_new;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [pdfst_pkg::FREE_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] opcode_i = '0;
  logic [pdfst_pkg::HEAP_W-1:0] heap_id_i = '0;
  logic [pdfst_pkg::PAGE_W-1:0] page_id_i = '0;
  logic [pdfst_pkg::BLOCK_W-1:0] disk_block_i = '0;
  logic [pdfst_pkg::FREE_W-1:0] free_space_i = '0;
  logic signed [7:0] delta_i = '0;
  logic [pdfst_pkg::BLOCK_W-1:0] new_block_i = '0;
  logic new_block_ok_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic [pdfst_pkg::HEAP_W-1:0] result_heap_o;
  logic [pdfst_pkg::PAGE_W-1:0] result_page_o;
  logic [pdfst_pkg::BLOCK_W-1:0] result_block_o;
  logic page_is_new_o;

  page_directory_free_space_table u_top (.*);

  always #10 clk_i = ~clk_i;

  // directory mirror
  logic [pdfst_pkg::FREE_W-1:0]  dflt_free;
  logic                          heap_used [pdfst_pkg::NUM_HEAPS];
  logic                          page_used [pdfst_pkg::NUM_PAGES];
  logic [pdfst_pkg::HEAP_W-1:0]  dir_heap [pdfst_pkg::NUM_PAGES];
  logic [pdfst_pkg::PAGE_W-1:0]  dir_page [pdfst_pkg::NUM_PAGES];
  logic [pdfst_pkg::BLOCK_W-1:0] dir_block [pdfst_pkg::NUM_PAGES];
  logic [pdfst_pkg::FREE_W-1:0]  dir_free [pdfst_pkg::NUM_PAGES];
  int                            dir_fill;

  answer_t pending_answers[$];
  int  errors = 0;
  int  in_idle_pct = 0;
  int  out_idle_pct = 0;
  int  holds_asked = 0;
  int  holds_served = 0;
  int  hold_left = 0;

  function automatic int find_entry(logic [pdfst_pkg::HEAP_W-1:0] h,
                                    logic [pdfst_pkg::PAGE_W-1:0] p);
    for (int i = 0; i < dir_fill; i++)
      if (dir_heap[i] == h && dir_page[i] == p) return i;
    return -1;
  endfunction

  function automatic answer_t apply_request(logic [2:0] op,
      logic [pdfst_pkg::HEAP_W-1:0] h, logic [pdfst_pkg::PAGE_W-1:0] p,
      logic [pdfst_pkg::BLOCK_W-1:0] blk, logic [pdfst_pkg::FREE_W-1:0] fr,
      logic signed [7:0] d, logic [pdfst_pkg::BLOCK_W-1:0] nblk, logic nok);
    answer_t a;
    int s;
    int v;
    bit found;
    a = '0;
    case (op)
      pdfst_pkg::OP_CREATE: begin
        a.status = pdfst_pkg::ST_NOSPACE;
        for (int i = 0; i < pdfst_pkg::NUM_HEAPS; i++)
          if (!heap_used[i]) begin
            heap_used[i] = 1'b1;
            a.heap = pdfst_pkg::HEAP_W'(i);
            a.status = pdfst_pkg::ST_OK;
            break;
          end
      end
      pdfst_pkg::OP_ADD: begin
        if (!heap_used[h]) a.status = pdfst_pkg::ST_NOTFOUND;
        else if (dir_fill >= pdfst_pkg::NUM_PAGES) a.status = pdfst_pkg::ST_NOSPACE;
        else begin
          dir_heap[dir_fill] = h;
          dir_page[dir_fill] = p;
          dir_block[dir_fill] = blk;
          dir_free[dir_fill] = fr;
          dir_fill++;
          page_used[p] = 1'b1;
        end
      end
      pdfst_pkg::OP_UPDATE, pdfst_pkg::OP_FETCH: begin
        s = heap_used[h] ? find_entry(h, p) : -1;
        if (s < 0) a.status = pdfst_pkg::ST_NOTFOUND;
        else if (op == pdfst_pkg::OP_FETCH) a.block = dir_block[s];
        else begin
          v = int'(dir_free[s]) + int'(d);
          if (v < 0) v = 0;
          if (v > 255) v = 255;
          dir_free[s] = pdfst_pkg::FREE_W'(v);
        end
      end
      pdfst_pkg::OP_GETFREE: begin
        if (!heap_used[h]) a.status = pdfst_pkg::ST_NOTFOUND;
        else begin
          found = 1'b0;
          for (int i = 0; i < dir_fill; i++)
            if (dir_heap[i] == h && dir_free[i] != 0) begin
              a.page = dir_page[i];
              a.block = dir_block[i];
              found = 1'b1;
              break;
            end
          if (!found) begin
            a.status = pdfst_pkg::ST_NOSPACE;
            if (nok && dir_fill < pdfst_pkg::NUM_PAGES)
              for (int i = 0; i < pdfst_pkg::NUM_PAGES; i++)
                if (!page_used[i]) begin
                  page_used[i] = 1'b1;
                  dir_heap[dir_fill] = h;
                  dir_page[dir_fill] = pdfst_pkg::PAGE_W'(i);
                  dir_block[dir_fill] = nblk;
                  dir_free[dir_fill] = dflt_free;
                  dir_fill++;
                  a.page = pdfst_pkg::PAGE_W'(i);
                  a.block = nblk;
                  a.is_new = 1'b1;
                  a.status = pdfst_pkg::ST_OK;
                  break;
                end
          end
        end
      end
      default: a.status = pdfst_pkg::ST_NOTFOUND;
    endcase
    if (a.status != pdfst_pkg::ST_OK) a = '{status: a.status, default: '0};
    return a;
  endfunction

  task automatic send_request(logic [2:0] op, logic [pdfst_pkg::HEAP_W-1:0] h,
      logic [pdfst_pkg::PAGE_W-1:0] p, logic [pdfst_pkg::BLOCK_W-1:0] blk,
      logic [pdfst_pkg::FREE_W-1:0] fr, logic signed [7:0] d,
      logic [pdfst_pkg::BLOCK_W-1:0] nblk, logic nok);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    pending_answers.push_back(apply_request(op, h, p, blk, fr, d, nblk, nok));
    in_valid_i <= 1'b1;
    opcode_i <= op;
    heap_id_i <= h;
    page_id_i <= p;
    disk_block_i <= blk;
    free_space_i <= fr;
    delta_i <= d;
    new_block_i <= nblk;
    new_block_ok_i <= nok;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_random(int n);
    logic [2:0] op;
    logic [pdfst_pkg::HEAP_W-1:0] h;
    for (int k = 0; k < n; k++) begin
      op = $urandom_range(99) < 95 ? 3'($urandom_range(4)) : 3'($urandom_range(7, 5));
      h = $urandom_range(99) < 85 ? 4'($urandom_range(3)) : 4'($urandom);
      send_request(op, h, $urandom_range(99) < 70 ? 8'($urandom_range(40)) : 8'($urandom),
                   16'($urandom), $urandom_range(99) < 30 ? 8'd0 : 8'($urandom),
                   8'($urandom), 16'($urandom), $urandom_range(99) < 85);
    end
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  task automatic write_default(logic [pdfst_pkg::FREE_W-1:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dflt_free = val;
  endtask

  task automatic test_directed;
    send_request(pdfst_pkg::OP_ADD, 4'd0, 8'd1, 16'h1, 8'd1, 8'sd0, 16'h0, 1'b1);
    send_request(3'd7, 4'd15, 8'd255, 16'hffff, 8'hff, -8'sd128, 16'hffff, 1'b1);
    send_request(pdfst_pkg::OP_CREATE, 4'd0, 8'd0, 16'h0, 8'd0, 8'sd0, 16'h0, 1'b0);
    send_request(pdfst_pkg::OP_GETFREE, 4'd0, 8'd0, 16'h0, 8'd0, 8'sd0, 16'hbeef, 1'b0);
    send_request(pdfst_pkg::OP_GETFREE, 4'd0, 8'd0, 16'h0, 8'd0, 8'sd0, 16'hbeef, 1'b1);
    send_request(pdfst_pkg::OP_ADD, 4'd0, 8'd255, 16'hffff, 8'd0, 8'sd0, 16'h0, 1'b0);
    send_request(pdfst_pkg::OP_ADD, 4'd0, 8'd255, 16'h1234, 8'd250, 8'sd0, 16'h0, 1'b0);
    send_request(pdfst_pkg::OP_UPDATE, 4'd0, 8'd255, 16'h0, 8'd0, 8'sd127, 16'h0, 1'b0);
    send_request(pdfst_pkg::OP_UPDATE, 4'd0, 8'd255, 16'h0, 8'd0, -8'sd128, 16'h0, 1'b0);
    send_request(pdfst_pkg::OP_UPDATE, 4'd0, 8'd255, 16'h0, 8'd0, -8'sd128, 16'h0, 1'b0);
    send_request(pdfst_pkg::OP_FETCH, 4'd0, 8'd255, 16'h0, 8'd0, 8'sd0, 16'h0, 1'b0);
    send_request(pdfst_pkg::OP_FETCH, 4'd0, 8'd77, 16'h0, 8'd0, 8'sd0, 16'h0, 1'b0);
    send_request(pdfst_pkg::OP_UPDATE, 4'd0, 8'd0, 16'h0, 8'd0, -8'sd128, 16'h0, 1'b0);
    send_request(pdfst_pkg::OP_GETFREE, 4'd0, 8'd0, 16'h0, 8'd0, 8'sd0, 16'h0001, 1'b1);
    send_request(pdfst_pkg::OP_FETCH, 4'd9, 8'd0, 16'h0, 8'd0, 8'sd0, 16'h0, 1'b0);
    repeat (16)
      send_request(pdfst_pkg::OP_CREATE, 4'd0, 8'd0, 16'h0, 8'd0, 8'sd0, 16'h0, 1'b0);
  endtask

  task automatic test_idling;
    write_default(8'd0);
    in_idle_pct = 36; out_idle_pct = 61;
    send_random(160);
    write_default(8'd255);
    in_idle_pct = 61; out_idle_pct = 36;
    send_random(160);
    write_default(8'd4);
    in_idle_pct = 0; out_idle_pct = 0;
    send_random(100);
  endtask

  task automatic test_pressure;
    holds_asked++;
    send_random(20);
    drain();
    send_random(20);
  endtask

  task automatic test_full_directory;
    write_default(8'd1);
    while (dir_fill < pdfst_pkg::NUM_PAGES)
      send_request(pdfst_pkg::OP_ADD, 4'd1, 8'($urandom), 16'($urandom), 8'd0, 8'sd0,
                   16'h0, 1'b0);
    repeat (4)
      send_request(pdfst_pkg::OP_ADD, 4'd1, 8'($urandom), 16'($urandom), 8'd0, 8'sd0,
                   16'h0, 1'b0);
    send_request(pdfst_pkg::OP_GETFREE, 4'd1, 8'd0, 16'h0, 8'd0, 8'sd0, 16'h5, 1'b1);
    send_random(120);
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_served + 1;
      hold_left <= 400;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= $urandom_range(99) < out_idle_pct;
    end
  end

  always @(posedge clk_i) begin
    answer_t got;
    answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{status_o, result_heap_o, result_page_o, result_block_o, page_is_new_o};
      if (pending_answers.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: expected st %0d h %0d p %0d b %h n %0d,",
                      " got st %0d h %0d p %0d b %h n %0d"},
                     want.status, want.heap, want.page, want.block, want.is_new,
                     got.status, got.heap, got.page, got.block, got.is_new);
        end
      end
    end
  end

  initial begin
    dflt_free = pdfst_pkg::DEFAULT_FREE_RST;
    dir_fill = 0;
    foreach (heap_used[i]) heap_used[i] = 1'b0;
    foreach (page_used[i]) page_used[i] = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_idling();
    test_pressure();
    test_full_directory();
    drain();
    if (errors == 0 && pending_answers.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #40000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> filelist.f
rtl/pdfst_pkg.sv
rtl/pdfst_ram.sv
rtl/pdfst_dp.sv
rtl/pdfst_ctrl.sv
rtl/page_directory_free_space_table.sv
dv/tb_page_directory_free_space_table.sv
